// ----- rtl/bcm_pkg.sv -----
`default_nettype none

package bcm_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);

  // widths fixed by the register map and the result word
  localparam int MODE_W = 3;
  localparam int SIZE_W = 11;
  localparam int OUT_W  = 10;
  localparam int MIN_DIM = 2;

  // effective sizes must hold the register value and MAX_* itself
  localparam int DIM_A = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
  localparam int DIM_W = (ROW_W + 1 > DIM_A) ? ROW_W + 1 : DIM_A;

  // APB
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS = 2'd2;

  // work queue between front and back (power-of-two depth)
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INVERT   = 3'd0,
    MODE_ERODE    = 3'd1,
    MODE_DILATE   = 3'd2,
    MODE_MAJORITY = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
  } cfg_t;

  typedef struct packed {
    logic             is_pixel;
    logic             pixel;
    logic             emit;
    logic             has_up;
    logic             has_right;
    logic             frame_end;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } work_t;

endpackage

`default_nettype wire

// ----- rtl/binary_cross_morphology_top.sv -----
`default_nettype none

// An accepted pixel word passes the queue, then the line store read, then the
// window and output register. Throughput: one word per cycle while the output
// is not stalled, limited by the single write port of the line store.
// Reset: mode erode, image 2 x 2, counters cleared, no row pending, queue empty.
// The line store is not cleared; no clearing pass runs after reset.

module binary_cross_morphology_top import bcm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              req_type_i,
  input  wire logic              pixel_in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   pixel_out_o,
  output logic [OUT_W-1:0]       out_row_o,
  output logic [OUT_W-1:0]       out_col_o,
  output logic                   frame_end_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [MODE_W-1:0]    mode_q;
  logic [SIZE_W-1:0]    rows_q, cols_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;
  cfg_t                 cfg;

  logic  accept, push, pop, fifo_full, fifo_empty;
  work_t push_work, head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ERODE;
      rows_q <= SIZE_W'(MIN_DIM);
      cols_q <= SIZE_W'(MIN_DIM);
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_MODE: mode_q <= pwdata[MODE_W-1:0];
        REG_ROWS: rows_q <= pwdata[SIZE_W-1:0];
        REG_COLS: cols_q <= pwdata[SIZE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE: prdata = DATA_W'(mode_q);
      REG_ROWS: prdata = DATA_W'(rows_q);
      REG_COLS: prdata = DATA_W'(cols_q);
      default:  prdata = '0;
    endcase
  end

  // sizes clamped to the range the line store supports
  assign cfg.mode = mode_q;
  assign cfg.rows = (rows_q < SIZE_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) :
                    (DIM_W'(rows_q) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) :
                    DIM_W'(rows_q);
  assign cfg.cols = (cols_q < SIZE_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) :
                    (DIM_W'(cols_q) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) :
                    DIM_W'(cols_q);

  assign in_ready_o = !fifo_full;
  assign accept     = in_valid_i && in_ready_o;

  bcm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .pixel_in_i (pixel_in_i),
    .push_o     (push),
    .work_o     (push_work)
  );

  bcm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_work),
    .pop_i       (pop),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty),
    .head_o      (head)
  );

  bcm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (cfg.mode),
    .fifo_empty_i (fifo_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_o  (pixel_out_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

`default_nettype wire

// ----- rtl/bcm_front.sv -----
`default_nettype none

module bcm_front import bcm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  accept_i,
  input  wire logic  req_type_i,
  input  wire logic  pixel_in_i,
  output logic       push_o,
  output work_t      work_o
);

  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [COL_W:0]   drain_col_q, drain_col_d;
  logic             draining_q, draining_d;

  logic [ROW_W:0] row_w, r_inc;
  logic [COL_W:0] col_w, c_inc, dc_inc;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic last_col, last_row, drain_last, drain_done;

  always_comb begin
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    drain_col_d = drain_col_q;
    draining_d  = draining_q;
    push_o      = 1'b0;
    work_o      = '0;

    // a pixel arriving mid drain starts a new image
    row_w = draining_q ? '0 : {1'b0, in_row_q};
    col_w = draining_q ? '0 : {1'b0, in_col_q};
    if (DIM_W'(col_w) >= cfg_i.cols) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end
    if (DIM_W'(row_w) >= cfg_i.rows) begin
      row_w = '0;
    end
    r        = row_w[ROW_W-1:0];
    c        = col_w[COL_W-1:0];
    c_inc    = {1'b0, c} + 1'b1;
    r_inc    = {1'b0, r} + 1'b1;
    last_col = DIM_W'(c_inc) >= cfg_i.cols;
    last_row = DIM_W'(r_inc) >= cfg_i.rows;

    dc_inc     = drain_col_q + 1'b1;
    drain_last = DIM_W'(dc_inc) >= cfg_i.cols;
    drain_done = DIM_W'(drain_col_q) >= cfg_i.cols;

    if (accept_i) begin
      if (req_type_i == REQ_PIXEL) begin
        push_o           = 1'b1;
        work_o.is_pixel  = 1'b1;
        work_o.pixel     = pixel_in_i;
        work_o.emit      = (r != '0);
        work_o.has_up    = (r >= ROW_W'(2));
        work_o.has_right = !last_col;
        work_o.frame_end = 1'b0;
        work_o.row       = r - 1'b1;
        work_o.col       = c;
        draining_d       = 1'b0;
        if (last_col) begin
          in_col_d = '0;
          if (last_row) begin
            in_row_d    = '0;
            draining_d  = 1'b1;
            drain_col_d = '0;
          end else begin
            in_row_d = r_inc[ROW_W-1:0];
          end
        end else begin
          in_col_d = c_inc[COL_W-1:0];
          in_row_d = r;
        end
      end else if (draining_q) begin
        if (drain_done) begin
          draining_d  = 1'b0;
          drain_col_d = '0;
        end else begin
          push_o           = 1'b1;
          work_o.is_pixel  = 1'b0;
          work_o.pixel     = 1'b0;
          work_o.emit      = 1'b1;
          work_o.has_up    = 1'b1;
          work_o.has_right = !drain_last;
          work_o.frame_end = drain_last;
          work_o.row       = ROW_W'(cfg_i.rows - 1'b1);
          work_o.col       = drain_col_q[COL_W-1:0];
          if (drain_last) begin
            draining_d  = 1'b0;
            drain_col_d = '0;
          end else begin
            drain_col_d = dc_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      drain_col_q <= '0;
      draining_q  <= 1'b0;
    end else begin
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      drain_col_q <= drain_col_d;
      draining_q  <= draining_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bcm_fifo.sv -----
`default_nettype none

module bcm_fifo import bcm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire work_t push_data_i,
  input  wire logic  pop_i,
  output logic       full_o,
  output logic       empty_o,
  output work_t      head_o
);

  work_t                 slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bcm_back.sv -----
`default_nettype none

module bcm_back import bcm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic             fifo_empty_i,
  input  wire work_t            head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  pixel_out_o,
  output logic [OUT_W-1:0]      out_row_o,
  output logic [OUT_W-1:0]      out_col_o,
  output logic                  frame_end_o
);

  // line store: bit 1 older row, bit 0 newer row
  logic [1:0] mem [MAX_COLS];

  work_t      b_q;
  logic       b_valid_q;
  logic [1:0] rd_c_q, rd_n_q;
  logic       left_q;

  logic             out_valid_q, pix_q, fend_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;

  logic             b_fire, wr_en, centre, result;
  logic [COL_W-1:0] wr_addr, rd_addr_c, rd_addr_n;
  logic [1:0]       wr_data;
  logic [3:0]       has, nb, diff;
  logic [2:0]       n, d;
  logic             any_set, all_set;

  assign b_fire = b_valid_q && (!b_q.emit || !out_valid_q || out_ready_i);
  assign pop_o  = !fifo_empty_i && (!b_valid_q || b_fire);

  assign centre    = rd_c_q[0];
  assign wr_en     = b_fire;
  assign wr_addr   = b_q.col;
  assign wr_data   = {centre, b_q.is_pixel & b_q.pixel};
  assign rd_addr_c = head_i.col;
  assign rd_addr_n = head_i.col + 1'b1;

  // up, down, left, right
  assign has  = {b_q.has_up, b_q.is_pixel, (b_q.col != '0), b_q.has_right};
  assign nb   = {rd_c_q[1], b_q.pixel, left_q, rd_n_q[0]};
  assign diff = has & (nb ^ {4{centre}});
  assign n    = 3'($countones(has));
  assign d    = 3'($countones(diff));
  assign any_set = |(has & nb);
  assign all_set = &(~has | nb);

  always_comb begin
    unique case (mode_i)
      MODE_INVERT:   result = ~centre;
      MODE_ERODE:    result = centre & all_set;
      MODE_DILATE:   result = centre | any_set;
      MODE_MAJORITY: result = centre ^ (((n == 3'd3) && (d == 3'd3)) ||
                                        ((n == 3'd4) && (d >= 3'd3)));
      default:       result = 1'b0;
    endcase
  end

  // write-first: a read of the word being written this cycle sees the new data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (pop_o) begin
      b_q    <= head_i;
      rd_c_q <= (wr_en && wr_addr == rd_addr_c) ? wr_data : mem[rd_addr_c];
      rd_n_q <= (wr_en && wr_addr == rd_addr_n) ? wr_data : mem[rd_addr_n];
    end
    if (b_fire) begin
      left_q <= centre;
    end
    if (b_fire && b_q.emit) begin
      pix_q  <= result;
      row_q  <= b_q.row;
      col_q  <= b_q.col;
      fend_q <= b_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire && b_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_q;
  assign out_row_o   = OUT_W'(row_q);
  assign out_col_o   = OUT_W'(col_q);
  assign frame_end_o = fend_q;

  a_emit_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fire && b_q.emit |=> out_valid_q)
    else $error("emitted word lost before output register");

  a_stall_holds_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_q.emit && out_valid_q && !out_ready_i |=> b_valid_q && $stable(b_q))
    else $error("work item changed while output stalled");

  a_frame_end_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fire && b_q.frame_end |-> !b_q.is_pixel && !b_q.has_right)
    else $error("frame end on a word other than the last drained column");

endmodule

`default_nettype wire
